// ----- rtl/dqs_pkg.sv -----
`default_nettype none

package dqs_pkg;

  // Queue geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Operation codes carried by an input transfer
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // What a cell does on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_cmd_e;

  // One result item
  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [IDX_W-1:0] found_position;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/deque_with_search_top.sv -----
`default_nettype none

// Bounded double-ended queue of 16 signed 32-bit entries, held in order in a
// chain of cells with cell 0 at the front. Push front shifts the chain one
// cell back, pop front shifts it one cell forward, push back writes the cell
// just past the last entry and pop back only lowers the count; these and
// clear finish on acceptance, and the result is registered into the output
// register, or into the pending slot while the output is stalled. Find
// rotates the whole chain once round through cell 0, where the key is
// compared against the stored entries only, whatever the fill level; the
// order is restored by the full rotation and no new transfer is accepted
// until the find is done. One result waiting on a stalled output does not
// block the next transfer; a second one does.
module deque_with_search_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [2:0]                       operation_i,
  input  wire logic signed [dqs_pkg::DATA_W-1:0] value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [1:0]                       status_o,
  output logic                                  found_o,
  output logic      [dqs_pkg::IDX_W-1:0]        found_position_o,
  output logic      [dqs_pkg::CNT_W-1:0]        entry_count_o,
  output logic                                  is_empty_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIND = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [dqs_pkg::CNT_W-1:0]    count_q, count_d;
  logic [dqs_pkg::IDX_W-1:0]    step_q, step_d;
  logic                         hit_q, hit_d;
  logic [dqs_pkg::IDX_W-1:0]    pos_q, pos_d;
  logic [dqs_pkg::DATA_W-1:0]   key_q;
  logic                         out_valid_q, out_valid_d;
  logic                         pend_q, pend_d;
  dqs_pkg::res_t                out_q, pend_res_q, res;

  logic                         accept, full, empty, res_fire, out_free, match;
  logic                         push_front, push_back, shift_fwd;
  dqs_pkg::op_e                 op;
  logic [dqs_pkg::DATA_W-1:0]   cell_data [dqs_pkg::DEPTH];
  dqs_pkg::cell_cmd_e           cell_cmd  [dqs_pkg::DEPTH];

  assign op       = dqs_pkg::op_e'(operation_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (count_q == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Front cell against the key, only within the stored entries
  assign match = !hit_q && (cell_data[0] == key_q) &&
                 ({1'b0, step_q} < count_q);

  // Operation decode and find sequencing
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    hit_d      = hit_q;
    pos_d      = pos_q;
    push_front = 1'b0;
    push_back  = 1'b0;
    shift_fwd  = 1'b0;
    res_fire   = 1'b0;
    res        = '0;
    res.status = dqs_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          unique case (op)
            dqs_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res.status = dqs_pkg::ST_FULL;
              end else begin
                push_front = 1'b1;
                count_d    = count_q + 1'b1;
              end
            end
            dqs_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res.status = dqs_pkg::ST_FULL;
              end else begin
                push_back = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            dqs_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res.status = dqs_pkg::ST_EMPTY;
              end else begin
                shift_fwd = 1'b1;
                count_d   = count_q - 1'b1;
              end
            end
            dqs_pkg::OP_POP_BACK: begin
              if (empty) begin
                res.status = dqs_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            dqs_pkg::OP_FIND: begin
              res_fire = 1'b0;
              state_d  = S_FIND;
              step_d   = '0;
              hit_d    = 1'b0;
              pos_d    = '0;
            end
            dqs_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        // rotate one cell per cycle through all DEPTH cells
        shift_fwd = 1'b1;
        step_d    = step_q + 1'b1;
        if (match) begin
          hit_d = 1'b1;
          pos_d = step_q;
        end
        if (step_q == dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)) begin
          res_fire           = 1'b1;
          state_d            = S_IDLE;
          res.found          = hit_q || match;
          res.found_position = hit_q ? pos_q : (match ? step_q : '0);
        end
      end
      default: state_d = S_IDLE;
    endcase
    res.entry_count = count_d;
    res.is_empty    = (count_d == '0);
  end

  // Per-cell commands and the chain itself
  for (genvar k = 0; k < dqs_pkg::DEPTH; k++) begin : g_cell
    always_comb begin
      priority if (push_front) begin
        cell_cmd[k] = (k == 0) ? dqs_pkg::CELL_LOAD : dqs_pkg::CELL_FROM_PREV;
      end else if (push_back && (count_q == dqs_pkg::CNT_W'(k))) begin
        cell_cmd[k] = dqs_pkg::CELL_LOAD;
      end else if (shift_fwd) begin
        cell_cmd[k] = dqs_pkg::CELL_FROM_NEXT;
      end else begin
        cell_cmd[k] = dqs_pkg::CELL_HOLD;
      end
    end

    dqs_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd[k]),
      .value_i (value_i),
      .prev_i  (cell_data[(k + dqs_pkg::DEPTH - 1) % dqs_pkg::DEPTH]),
      .next_i  (cell_data[(k + 1) % dqs_pkg::DEPTH]),
      .data_o  (cell_data[k])
    );
  end

  // Output register with one pending slot behind it
  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = pend_q || res_fire;
      pend_d      = 1'b0;
    end else if (res_fire) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (accept && op == dqs_pkg::OP_FIND) begin
      key_q <= value_i;
    end
    if (out_free) begin
      out_q <= pend_q ? pend_res_q : res;
    end
    if (!out_free && res_fire) begin
      pend_res_q <= res;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE) || pend_q;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign found_o          = out_q.found;
  assign found_position_o = out_q.found_position;
  assign entry_count_o    = out_q.entry_count;
  assign is_empty_o       = out_q.is_empty;

endmodule

`default_nettype wire

// ----- rtl/dqs_cell.sv -----
`default_nettype none

// One storage cell of the chain: holds, loads a new value, or takes the
// entry of either neighbour.
module dqs_cell (
  input  wire logic                        clk_i,
  input  wire dqs_pkg::cell_cmd_e          cmd_i,
  input  wire logic [dqs_pkg::DATA_W-1:0]  value_i,
  input  wire logic [dqs_pkg::DATA_W-1:0]  prev_i,
  input  wire logic [dqs_pkg::DATA_W-1:0]  next_i,
  output logic      [dqs_pkg::DATA_W-1:0]  data_o
);

  logic [dqs_pkg::DATA_W-1:0] data_q, data_d;

  // Next entry select
  always_comb begin
    unique case (cmd_i)
      dqs_pkg::CELL_HOLD:      data_d = data_q;
      dqs_pkg::CELL_LOAD:      data_d = value_i;
      dqs_pkg::CELL_FROM_PREV: data_d = prev_i;
      dqs_pkg::CELL_FROM_NEXT: data_d = next_i;
      default:                 data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/dqs_checker.sv -----
`default_nettype none

module dqs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [1:0]                  status_o,
  input wire logic                        found_o,
  input wire logic [dqs_pkg::IDX_W-1:0]   found_position_o,
  input wire logic [dqs_pkg::CNT_W-1:0]   entry_count_o,
  input wire logic                        is_empty_o
);

  // Count never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
    else $error("entry count beyond capacity");

  // Empty flag tracks the count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> found_position_o == '0)
    else $error("position set without a match");

  // A match only comes with ok status and a non-empty queue
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == dqs_pkg::ST_OK && !is_empty_o))
    else $error("match reported with bad status or empty queue");

  // Stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind deque_with_search_top dqs_checker u_dqs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .found_o          (found_o),
  .found_position_o (found_position_o),
  .entry_count_o    (entry_count_o),
  .is_empty_o       (is_empty_o)
);

`default_nettype wire
